// ===== rtl/lpue_pkg.sv =====
// ----------------------------------------------------------------------------
// lpue_pkg
// Types, constants and the pattern table that the LED pixel encoder shares.
// ----------------------------------------------------------------------------
package lpue_pkg;

  localparam int CHAN_W   = 8;
  localparam int BRIGHT_W = 9;
  localparam int WORD_W   = 3 * CHAN_W;
  localparam int GROUP_W  = 3;
  localparam int GROUPS   = WORD_W / GROUP_W;
  localparam int CNT_W    = $clog2(GROUPS);
  localparam int PROD_W   = CHAN_W + BRIGHT_W;

  localparam logic [BRIGHT_W-1:0] BRIGHT_MAX   = 9'd256;
  localparam logic [BRIGHT_W-1:0] BRIGHT_RESET = 9'd1;
  localparam logic [PROD_W-1:0]   ROUND_HALF   = 17'd128;
  localparam logic [CNT_W-1:0]    CNT_LAST     = 3'd7;

  typedef logic [CHAN_W-1:0]   chan_t;
  typedef logic [BRIGHT_W-1:0] bright_t;
  typedef logic [WORD_W-1:0]   word_t;
  typedef logic [GROUP_W-1:0]  group_t;
  typedef logic [CNT_W-1:0]    cnt_t;

  // One packed pixel on its way into the queue
  typedef struct packed {
    logic  valid;
    word_t word;
  } word_push_t;

  // Inverted line pattern for one 3-bit group
  function automatic chan_t pattern_of(input group_t g);
    chan_t p;
    begin
      case (g)
        3'd0:    p = 8'b00100010;
        3'd1:    p = 8'b00100011;
        3'd2:    p = 8'b00111010;
        3'd3:    p = 8'b00111011;
        3'd4:    p = 8'b10100010;
        3'd5:    p = 8'b10100011;
        3'd6:    p = 8'b10111010;
        default: p = 8'b10111011;
      endcase
      pattern_of = ~p;
    end
  endfunction

endpackage

// ===== rtl/lpue_front.sv =====
// ----------------------------------------------------------------------------
// lpue_front
// Holds the brightness register, scales the three channels of an accepted
// pixel and packs them green, red, blue into one word for the queue.
// ----------------------------------------------------------------------------
module lpue_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 brightness_we,
  input  lpue_pkg::bright_t    brightness,
  input  logic                 push,
  input  lpue_pkg::chan_t      red,
  input  lpue_pkg::chan_t      green,
  input  lpue_pkg::chan_t      blue,
  input  logic                 q_full,
  output lpue_pkg::word_push_t q_push
);
  import lpue_pkg::*;

  bright_t bright_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      bright_reg <= BRIGHT_RESET;
    end else if (brightness_we) begin
      bright_reg <= (brightness > BRIGHT_MAX) ? BRIGHT_MAX : brightness;
    end
  end

  function automatic chan_t scale(input chan_t c, input bright_t b);
    logic [PROD_W-1:0] prod;
    begin
      prod  = PROD_W'(c) * PROD_W'(b) + ROUND_HALF;
      scale = prod[CHAN_W+7:8];
    end
  endfunction

  always_comb begin
    q_push.valid = push && !q_full;
    q_push.word  = {scale(green, bright_reg), scale(red, bright_reg),
                    scale(blue, bright_reg)};
  end

endmodule

// ===== rtl/lpue_queue.sv =====
// ----------------------------------------------------------------------------
// lpue_queue
// Short queue of packed pixel words between the front and the back.
// ----------------------------------------------------------------------------
module lpue_queue #(
  parameter int DEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  lpue_pkg::word_push_t q_push,
  output logic                 q_full,
  input  logic                 q_pop,
  output logic                 q_empty,
  output lpue_pkg::word_t      q_data
);
  import lpue_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_DEPTH = CW'(DEPTH);

  word_t         entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign q_full  = (count == CNT_DEPTH);
  assign q_empty = (count == '0);
  assign q_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (q_push.valid) begin
      entries[wr_ptr] <= q_push.word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.valid) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({q_push.valid, q_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_DEPTH)
    else $error("queue count beyond depth");

endmodule

// ===== rtl/lpue_back.sv =====
// ----------------------------------------------------------------------------
// lpue_back
// Cuts each queued word into eight 3-bit groups, top group first, and
// drives one pattern byte per cycle through the output register while each byte is popped.
// ----------------------------------------------------------------------------
module lpue_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  input  lpue_pkg::word_t q_data,
  output logic            q_pop,
  output logic            empty,
  input  logic            pop,
  output lpue_pkg::chan_t line_byte,
  output logic            last_of_pixel
);
  import lpue_pkg::*;

  word_t  word;
  cnt_t   cnt;
  logic   active;
  logic   out_valid;
  logic   load_ok;
  logic   take_q;
  logic   step;
  logic   last_now;
  group_t cur_group;

  assign load_ok   = !out_valid || pop;
  assign take_q    = !active && !q_empty && load_ok;
  assign step      = active && load_ok;
  assign last_now  = active && (cnt == CNT_LAST);
  assign cur_group = active ? word[WORD_W-1 -: GROUP_W] : q_data[WORD_W-1 -: GROUP_W];
  assign q_pop     = take_q;
  assign empty     = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
    end else if (take_q) begin
      active <= 1'b1;
      cnt    <= cnt_t'(1);
    end else if (step) begin
      // drop out of the pixel after its eighth group
      active <= !last_now;
      cnt    <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_q) begin
      word <= q_data << GROUP_W;
    end else if (step) begin
      word <= word << GROUP_W;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take_q || step) begin
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take_q || step) begin
      line_byte     <= pattern_of(cur_group);
      last_of_pixel <= last_now;
    end
  end

  a_idle_cnt: assert property (@(posedge clk) disable iff (rst)
    !active |-> cnt == '0)
    else $error("group count not cleared while idle");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    step && last_now |=> !active && out_valid && last_of_pixel)
    else $error("final group did not close the pixel");

  a_take_first: assert property (@(posedge clk) disable iff (rst)
    take_q |=> active && cnt == cnt_t'(1) && out_valid && !last_of_pixel)
    else $error("first group of a pixel not started correctly");

endmodule

// ===== rtl/led_pixel_uart_encoder.sv =====
// A transferred pixel is written to a queue entry, then its first byte to the back end's output register.
// Throughput: one line byte per cycle while each byte is popped, set by the single
//   output register of the back end; pixels queue in DEPTH entries meanwhile.
// Reset (rst, synchronous): brightness returns to 1, queue and output empty.
// ----------------------------------------------------------------------------
// led_pixel_uart_encoder
// Scales an RGB pixel by brightness and emits eight inverted line bytes.
// ----------------------------------------------------------------------------
module led_pixel_uart_encoder #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              brightness_we,
  input  lpue_pkg::bright_t brightness,
  input  logic              push,
  output logic              full,
  input  lpue_pkg::chan_t   red,
  input  lpue_pkg::chan_t   green,
  input  lpue_pkg::chan_t   blue,
  output logic              empty,
  input  logic              pop,
  output lpue_pkg::chan_t   line_byte,
  output logic              last_of_pixel
);
  import lpue_pkg::*;

  word_push_t q_push;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  word_t      q_data;

  assign full = q_full;

  lpue_front u_front (
    .clk           (clk),
    .rst           (rst),
    .brightness_we (brightness_we),
    .brightness    (brightness),
    .push          (push),
    .red           (red),
    .green         (green),
    .blue          (blue),
    .q_full        (q_full),
    .q_push        (q_push)
  );

  lpue_queue #(
    .DEPTH (DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_push  (q_push),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_data  (q_data)
  );

  lpue_back u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .line_byte     (line_byte),
    .last_of_pixel (last_of_pixel)
  );

endmodule
